// ----- rtl/alid_pkg.sv -----
package alid_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = $clog2(CAPACITY);
  localparam int CNT_W      = POS_W + 1;

  localparam logic [CNT_W-1:0] MAXLEN_RESET = CNT_W'(50);
  localparam logic [CNT_W-1:0] CAP_LIMIT    = CNT_W'(CAPACITY);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] ADDR_MAX_LENGTH = 2'd0;

  typedef struct packed {
    logic [1:0]            command;
    logic [POS_W-1:0]      position;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      count;
  } rsp_t;

  typedef struct packed {
    logic                  ins_en;
    logic                  del_en;
    logic [POS_W-1:0]      pos;
    logic [CNT_W-1:0]      cnt;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctl_t;

endpackage

// ----- rtl/alid_cell.sv -----
module alid_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  alid_pkg::cell_ctl_t                 ctl,
  input  logic [alid_pkg::POS_W-1:0]          idx,
  input  logic [alid_pkg::DATA_WIDTH-1:0]     left,
  input  logic [alid_pkg::DATA_WIDTH-1:0]     right,
  output logic [alid_pkg::DATA_WIDTH-1:0]     data,
  output logic [alid_pkg::DATA_WIDTH-1:0]     rd_word
);
  import alid_pkg::*;

  logic [CNT_W-1:0] idx_ext;

  assign idx_ext = {1'b0, idx};
  assign rd_word = (idx == ctl.pos) ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (ctl.ins_en) begin
      if (idx == ctl.pos) begin
        data <= ctl.value;
      end else if (idx > ctl.pos && idx_ext <= ctl.cnt) begin
        data <= left;
      end
    end else if (ctl.del_en) begin
      if (idx >= ctl.pos && (idx_ext + CNT_W'(1)) < ctl.cnt) begin
        data <= right;
      end
    end
  end

endmodule

// ----- rtl/alid_ctrl.sv -----
module alid_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  alid_pkg::cmd_t                cmd,
  input  logic [alid_pkg::CNT_W-1:0]    max_length,
  output alid_pkg::cell_ctl_t           ctl,
  output logic [1:0]                    status,
  output logic [alid_pkg::CNT_W-1:0]    cnt_next
);
  import alid_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] pos_ext;
  logic             full;

  assign limit   = (max_length > CAP_LIMIT) ? CAP_LIMIT : max_length;
  assign full    = cnt >= limit;
  assign pos_ext = {1'b0, cmd.position};

  always_comb begin
    status = ST_OK;
    unique case (cmd.command)
      CMD_APPEND: begin
        if (full) status = ST_FULL;
      end
      CMD_INSERT: begin
        priority if (full) status = ST_FULL;
        else if (pos_ext > cnt) status = ST_RANGE;
      end
      CMD_DELETE, CMD_READ: begin
        priority if (cnt == '0) status = ST_EMPTY;
        else if (pos_ext >= cnt) status = ST_RANGE;
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    ctl.ins_en = take && status == ST_OK &&
                 (cmd.command == CMD_APPEND || cmd.command == CMD_INSERT);
    ctl.del_en = take && status == ST_OK && cmd.command == CMD_DELETE;
    ctl.pos    = (cmd.command == CMD_APPEND) ? cnt[POS_W-1:0] : cmd.position;
    ctl.cnt    = cnt;
    ctl.value  = cmd.value;
    cnt_next   = cnt;
    if (ctl.ins_en) cnt_next = cnt + CNT_W'(1);
    else if (ctl.del_en) cnt_next = cnt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take) begin
      cnt <= cnt_next;
    end
  end

endmodule

// ----- rtl/array_list_insert_delete.sv -----
// Latency: a command's result is registered and valid in the cycle after its transfer.
// Throughput: one command per cycle unless stalled; affected cells shift in parallel.
// A new command is taken while the result register is empty or is being drained.
// Reset clears the count and all entries to zero and sets max_length to 50.
module array_list_insert_delete (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  alid_pkg::cmd_t       cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output alid_pkg::rsp_t       rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import alid_pkg::*;

  logic                  accept;
  logic [CNT_W-1:0]      max_length;
  cell_ctl_t             ctl;
  logic [1:0]            status;
  logic [CNT_W-1:0]      cnt_next;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_any;
  logic [DATA_WIDTH-1:0] rd_data;

  assign pready    = 1'b1;
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAXLEN_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_LENGTH) begin
      max_length <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_MAX_LENGTH) ? {{(32-CNT_W){1'b0}}, max_length} : '0;

  alid_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (accept),
    .cmd        (cmd),
    .max_length (max_length),
    .ctl        (ctl),
    .status     (status),
    .cnt_next   (cnt_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    alid_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .idx     (POS_W'(i)),
      .left    ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
      .right   ((i == CAPACITY - 1) ? '0 : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data    (cell_data[i]),
      .rd_word (rd_word[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd_word[i];
    end
  end

  assign rd_data = (status == ST_OK && cmd.command == CMD_READ) ? rd_any : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status    <= status;
      rsp.read_data <= rd_data;
      rsp.count     <= cnt_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |=> rsp_valid)
    else $error("Result missing after a transfer.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
    else $error("Failed command returned nonzero data.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= CAP_LIMIT)
    else $error("Count exceeds capacity.");

  assert property (@(posedge clk) disable iff (rst)
    accept && status != ST_OK |=> rsp.count == $past(ctl.cnt))
    else $error("Failed command changed the count.");

endmodule

// ----- tb/alid_list_monitor.sv -----
`timescale 1ns / 100ps

module alid_list_monitor (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  alid_pkg::cmd_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  alid_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic [31:0]    prdata,
  input  logic           pready,
  output int unsigned    mismatches,
  output int unsigned    outstanding,
  output int unsigned    list_len
);
  import alid_pkg::*;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]      entry_cnt;
  logic [CNT_W-1:0]      max_len;
  rsp_t                  due_rsp [$];

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic apply_list_cmd(input cmd_t c, output rsp_t r);
    logic [CNT_W-1:0] lim;
    lim = (max_len > CAP_LIMIT) ? CAP_LIMIT : max_len;
    r = '0;
    case (c.command)
      CMD_APPEND: begin
        if (entry_cnt >= lim) begin
          r.status = ST_FULL;
        end else begin
          entries[entry_cnt] = c.value;
          entry_cnt = entry_cnt + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (entry_cnt >= lim) begin
          r.status = ST_FULL;
        end else if (c.position > entry_cnt) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = int'(entry_cnt); i > int'(c.position); i--) begin
            entries[i] = entries[i-1];
          end
          entries[c.position] = c.value;
          entry_cnt = entry_cnt + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (entry_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position >= entry_cnt) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = int'(c.position); i + 1 < int'(entry_cnt); i++) begin
            entries[i] = entries[i+1];
          end
          entry_cnt = entry_cnt - 1'b1;
        end
      end
      default: begin
        if (entry_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position >= entry_cnt) begin
          r.status = ST_RANGE;
        end else begin
          r.read_data = entries[c.position];
        end
      end
    endcase
    r.count = entry_cnt;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] = '0;
      end
      entry_cnt = '0;
      max_len = MAXLEN_RESET;
      due_rsp.delete();
      mismatches = 0;
    end else begin
      // A result leaving at this edge belongs to an earlier transfer, so check it first.
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          note_mismatch("unexpected result", '0, 64'(rsp));
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status) begin
            note_mismatch("status", 64'(want.status), 64'(rsp.status));
          end
          if (rsp.read_data !== want.read_data) begin
            note_mismatch("read_data", 64'(want.read_data), 64'(rsp.read_data));
          end
          if (rsp.count !== want.count) begin
            note_mismatch("count", 64'(want.count), 64'(rsp.count));
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        apply_list_cmd(cmd, want);
        due_rsp.push_back(want);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_MAX_LENGTH) begin
            max_len = pwdata[CNT_W-1:0];
          end
        end else if (paddr == ADDR_MAX_LENGTH && prdata !== 32'(max_len)) begin
          note_mismatch("max_length readback", 64'(max_len), 64'(prdata));
        end
      end
    end
    outstanding = due_rsp.size();
    list_len = entry_cnt;
  end

endmodule

// ----- tb/array_list_insert_delete_tb.sv -----
`timescale 1ns / 100ps

module array_list_insert_delete_tb;
  import alid_pkg::*;

  typedef enum int {GROW, SHRINK, MIX} seg_mode_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned list_len;
  bit          hold_request;
  bit          gaps_off;

  array_list_insert_delete i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  alid_list_monitor i_list_monitor (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .list_len    (list_len)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random runs of stalls and free cycles, plus a long hold-off on request.
  initial begin
    int unsigned run;
    int unsigned r;
    bit          stall_now;
    run = 0;
    stall_now = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0 || hold_request) begin
        r = $urandom_range(0, 99);
        if (hold_request) begin
          hold_request = 1'b0;
          stall_now = 1'b1;
          run = 200;
        end else if (r < 45) begin
          stall_now = 1'b0;
          run = $urandom_range(1, 12);
        end else if (r < 80) begin
          stall_now = 1'b1;
          run = $urandom_range(1, 3);
        end else if (r < 88) begin
          stall_now = 1'b1;
          run = $urandom_range(8, 30);
        end else begin
          stall_now = 1'b0;
          run = $urandom_range(30, 60);
        end
      end
      rsp_stall <= stall_now;
      run--;
    end
  end

  function automatic cmd_t mk(input logic [1:0] command, input int unsigned position,
                              input logic [31:0] value);
    cmd_t c;
    c.command = command;
    c.position = POS_W'(position);
    c.value = value;
    return c;
  endfunction

  function automatic cmd_t make_list_cmd(input seg_mode_t mode);
    cmd_t        c;
    int unsigned r;
    int unsigned len;
    len = list_len;
    r = $urandom_range(0, 99);
    case (mode)
      GROW: begin
        c.command = (r < 45) ? CMD_APPEND : (r < 80) ? CMD_INSERT :
                    (r < 90) ? CMD_DELETE : CMD_READ;
      end
      SHRINK: begin
        c.command = (r < 8) ? CMD_APPEND : (r < 16) ? CMD_INSERT :
                    (r < 70) ? CMD_DELETE : CMD_READ;
      end
      default: begin
        c.command = (r < 25) ? CMD_APPEND : (r < 50) ? CMD_INSERT :
                    (r < 75) ? CMD_DELETE : CMD_READ;
      end
    endcase
    c.value = $urandom;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      c.value = '0;
    end else if (r < 10) begin
      c.value = '1;
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      c.position = POS_W'($urandom);
    end else if (c.command == CMD_INSERT) begin
      c.position = POS_W'($urandom_range(0, (len > 63) ? 63 : len));
    end else begin
      c.position = POS_W'($urandom_range(0, (len == 0) ? 0 : len - 1));
    end
    return c;
  endfunction

  function automatic int unsigned send_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gaps_off || r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    gap = send_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] data);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_LENGTH;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_segment(input seg_mode_t mode, input int unsigned target,
                             input int unsigned extra);
    int unsigned k;
    k = 0;
    while (k < 150 && ((mode == GROW && list_len < target) ||
                       (mode == SHRINK && list_len > 0) ||
                       (mode == MIX && k < target))) begin
      send_cmd(make_list_cmd(mode));
      k++;
    end
    repeat (extra) send_cmd(make_list_cmd(mode));
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_request = 1'b0;
    gaps_off = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list, bad positions, shifting inserts and deletes at the default capacity.
    send_cmd(mk(CMD_READ, 0, 32'h0));
    send_cmd(mk(CMD_DELETE, 63, 32'h0));
    send_cmd(mk(CMD_INSERT, 1, 32'h1111_1111));
    send_cmd(mk(CMD_INSERT, 0, 32'hFFFF_FFFF));
    send_cmd(mk(CMD_APPEND, 63, 32'h0));
    send_cmd(mk(CMD_INSERT, 2, 32'hA5A5_A5A5));
    send_cmd(mk(CMD_INSERT, 1, 32'h5A5A_5A5A));
    send_cmd(mk(CMD_READ, 0, 32'hFFFF_FFFF));
    send_cmd(mk(CMD_READ, 1, 32'h0));
    send_cmd(mk(CMD_READ, 3, 32'h0));
    send_cmd(mk(CMD_READ, 4, 32'h0));
    send_cmd(mk(CMD_READ, 63, 32'h0));
    send_cmd(mk(CMD_DELETE, 4, 32'h0));
    send_cmd(mk(CMD_DELETE, 1, 32'h0));
    send_cmd(mk(CMD_READ, 1, 32'h0));

    // Capacity equal to the count, then capacity zero with entries still held.
    write_max_length(32'd3);
    send_cmd(mk(CMD_APPEND, 0, 32'hDEAD_BEEF));
    send_cmd(mk(CMD_INSERT, 63, 32'hDEAD_BEEF));
    send_cmd(mk(CMD_DELETE, 2, 32'h0));
    send_cmd(mk(CMD_INSERT, 2, 32'h1234_5678));
    write_max_length(32'd0);
    send_cmd(mk(CMD_APPEND, 0, 32'h0000_0001));
    send_cmd(mk(CMD_READ, 2, 32'h0));
    repeat (3) send_cmd(mk(CMD_DELETE, 0, 32'h0));
    send_cmd(mk(CMD_DELETE, 0, 32'h0));

    // A capacity register above the array size saturates; fill the whole array.
    write_max_length(32'd127);
    run_segment(GROW, CAPACITY, 6);
    hold_request = 1'b1;
    gaps_off = 1'b1;
    run_segment(MIX, 40, 0);
    gaps_off = 1'b0;
    wait_idle();
    run_segment(MIX, 20, 0);

    // Capacity lowered far below the count.
    write_max_length(32'd2);
    run_segment(MIX, 20, 0);
    run_segment(SHRINK, 0, 5);

    write_max_length(32'd1);
    run_segment(GROW, 1, 6);
    run_segment(MIX, 15, 0);
    run_segment(SHRINK, 0, 3);

    write_max_length(32'd0);
    run_segment(MIX, 10, 0);

    write_max_length(32'd64);
    run_segment(GROW, CAPACITY, 5);
    run_segment(MIX, 30, 0);
    run_segment(SHRINK, 0, 4);

    write_max_length(32'd50);
    run_segment(GROW, 50, 5);
    run_segment(MIX, 40, 0);

    write_max_length($urandom_range(3, 63));
    run_segment(MIX, 40, 0);
    run_segment(SHRINK, 0, 3);

    write_max_length($urandom);
    gaps_off = 1'b1;
    run_segment(MIX, 50, 0);
    gaps_off = 1'b0;

    cmd_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (5) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
